// ----- src/view_transform_matrix_unit_macros.svh -----
// assertion macros shared by the view transform matrix unit
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef VIEW_TRANSFORM_MATRIX_UNIT_MACROS_SVH
`define VIEW_TRANSFORM_MATRIX_UNIT_MACROS_SVH

// consequent checked in the cycle after the antecedent
`define VTM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vtm assertion failed");

// consequent checked in the same cycle
`define VTM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vtm assertion failed");

`endif

// ----- src/vtm_pkg.sv -----
// shared constants and latency function for the view transform matrix unit
// no dependencies
package vtm_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // normalization scales the largest magnitude into [2^29, 2^30)
    localparam int SCALE_MSB   = 29;
    localparam int SCALED_W    = 30;
    localparam int SQ_W        = 63;
    localparam int SQRT_STEPS  = 32;
    localparam int LEN_W       = 32;

    localparam logic [1:0] ROW_LAST = 2'd3;

    // cycles from normalizer input register to its output register
    function automatic int norm_lat(input int frac);
        return 4 + SQRT_STEPS + 1 + (frac + 1) + 1;
    endfunction

endpackage

// ----- src/vtm_norm.sv -----
// pipelined vector normalizer: scale, sum of squares, sqrt, per-component divide
// depends on vtm_pkg
module vtm_norm #(
    parameter int W  = vtm_pkg::COORD_WIDTH_DEF,
    parameter int F  = vtm_pkg::FRAC_BITS_DEF,
    parameter int MW = vtm_pkg::COORD_WIDTH_DEF + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [MW-1:0] i_vec [3],
    output logic                 o_valid,
    output logic signed [W-1:0]  o_unit [3],
    output logic                 o_zero
);
    localparam int PW   = $clog2(MW + 1);
    localparam int SCW  = vtm_pkg::SCALED_W;
    localparam int SW   = MW + SCW;
    localparam int SQW  = vtm_pkg::SQ_W;
    localparam int NST  = vtm_pkg::SQRT_STEPS;
    localparam int LW   = vtm_pkg::LEN_W;
    localparam int DW   = LW + F;
    localparam int QW   = F + 1;
    localparam int EW   = ((W > F + 2) ? W : F + 2) + 1;
    localparam logic signed [EW-1:0] SMX = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [EW-1:0] SMN = ~SMX;

    // stage 1: magnitudes and leading one of their union
    logic [MW-1:0] n1_mag [3];
    logic [MW-1:0] or_all;
    logic [PW-1:0] n1_pos;
    logic [MW-1:0] r1_mag [3];
    logic [2:0]    r1_neg;
    logic [PW-1:0] r1_pos;
    logic          r1_zero, r1_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_mag[i] = i_vec[i][MW-1] ? MW'(-i_vec[i]) : MW'(i_vec[i]);
        end
        or_all = n1_mag[0] | n1_mag[1] | n1_mag[2];
        n1_pos = '0;
        for (int j = 0; j < MW; j++) begin
            if (or_all[j]) n1_pos = PW'(j);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_mag  <= n1_mag;
            r1_neg  <= {i_vec[2][MW-1], i_vec[1][MW-1], i_vec[0][MW-1]};
            r1_pos  <= n1_pos;
            r1_zero <= (or_all == '0);
        end
    end

    // stage 2: shift all magnitudes together
    logic [SW-1:0]  ext_m [3];
    logic [SCW-1:0] n2_m [3];
    logic [SCW-1:0] r2_m [3];
    logic [2:0]     r2_neg;
    logic           r2_zero, r2_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ext_m[i] = SW'(r1_mag[i]);
            if (r1_pos >= PW'(vtm_pkg::SCALE_MSB)) begin
                n2_m[i] = SCW'(ext_m[i] >> (r1_pos - PW'(vtm_pkg::SCALE_MSB)));
            end else begin
                n2_m[i] = SCW'(ext_m[i] << (PW'(vtm_pkg::SCALE_MSB) - r1_pos));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_m    <= n2_m;
            r2_neg  <= r1_neg;
            r2_zero <= r1_zero;
        end
    end

    // stage 3: squares
    logic [2*SCW-1:0] r3_sq [3];
    logic [SCW-1:0]   r3_m [3];
    logic [2:0]       r3_neg;
    logic             r3_zero, r3_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            for (int i = 0; i < 3; i++) r3_sq[i] <= r2_m[i] * r2_m[i];
            r3_m    <= r2_m;
            r3_neg  <= r2_neg;
            r3_zero <= r2_zero;
        end
    end

    // stage 4: sum of squares
    logic [SQW-1:0] r4_sum;
    logic [SCW-1:0] r4_m [3];
    logic [2:0]     r4_neg;
    logic           r4_zero, r4_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
        if (i_en) begin
            r4_sum  <= SQW'(r3_sq[0]) + SQW'(r3_sq[1]) + SQW'(r3_sq[2]);
            r4_m    <= r3_m;
            r4_neg  <= r3_neg;
            r4_zero <= r3_zero;
        end
    end

    // square root, one result bit per stage
    logic [SQW-1:0] sq_in_n [NST];
    logic [SQW-1:0] sq_in_r [NST];
    logic [SQW-1:0] sq_b    [NST];
    logic [SQW-1:0] sq_t    [NST];
    logic [SQW-1:0] n_sq_n  [NST];
    logic [SQW-1:0] n_sq_r  [NST];
    logic [SQW-1:0] r_sq_n  [NST];
    logic [SQW-1:0] r_sq_r  [NST];
    logic [SCW-1:0] r_sq_m  [NST][3];
    logic [2:0]     r_sq_neg  [NST];
    logic           r_sq_zero [NST];
    logic           r_sq_valid [NST];

    always_comb begin
        for (int k = 0; k < NST; k++) begin
            sq_in_n[k] = (k == 0) ? r4_sum : r_sq_n[(k == 0) ? 0 : k - 1];
            sq_in_r[k] = (k == 0) ? '0 : r_sq_r[(k == 0) ? 0 : k - 1];
            sq_b[k]    = SQW'(1) << (SQW - 1 - 2 * k);
            sq_t[k]    = sq_in_r[k] + sq_b[k];
            if (sq_in_n[k] >= sq_t[k]) begin
                n_sq_n[k] = sq_in_n[k] - sq_t[k];
                n_sq_r[k] = (sq_in_r[k] >> 1) + sq_b[k];
            end else begin
                n_sq_n[k] = sq_in_n[k];
                n_sq_r[k] = sq_in_r[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_sq_valid[k] <= 1'b0;
        end else if (i_en) begin
            r_sq_valid[0] <= r4_valid;
            for (int k = 1; k < NST; k++) r_sq_valid[k] <= r_sq_valid[k-1];
        end
        if (i_en) begin
            r_sq_n       <= n_sq_n;
            r_sq_r       <= n_sq_r;
            r_sq_m[0]    <= r4_m;
            r_sq_neg[0]  <= r4_neg;
            r_sq_zero[0] <= r4_zero;
            for (int k = 1; k < NST; k++) begin
                r_sq_m[k]    <= r_sq_m[k-1];
                r_sq_neg[k]  <= r_sq_neg[k-1];
                r_sq_zero[k] <= r_sq_zero[k-1];
            end
        end
    end

    // numerator with rounding term
    logic [LW-1:0] len_w;
    logic [DW-1:0] r_num [3];
    logic [LW-1:0] r_nm_len;
    logic [2:0]    r_nm_neg;
    logic          r_nm_zero, r_nm_valid;

    assign len_w = LW'(r_sq_r[NST-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm_valid <= 1'b0;
        end else if (i_en) begin
            r_nm_valid <= r_sq_valid[NST-1];
        end
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= (DW'(r_sq_m[NST-1][i]) << F) + DW'(len_w >> 1);
            end
            r_nm_len  <= len_w;
            r_nm_neg  <= r_sq_neg[NST-1];
            r_nm_zero <= r_sq_zero[NST-1];
        end
    end

    // restoring divide, one quotient bit per stage
    logic [DW-1:0] dv_in_rem [QW][3];
    logic [QW-1:0] dv_in_q   [QW][3];
    logic [LW-1:0] dv_in_len [QW];
    logic [DW-1:0] dv_den    [QW];
    logic [DW-1:0] n_dv_rem  [QW][3];
    logic [QW-1:0] n_dv_q    [QW][3];
    logic [DW-1:0] r_dv_rem  [QW][3];
    logic [QW-1:0] r_dv_q    [QW][3];
    logic [LW-1:0] r_dv_len  [QW];
    logic [2:0]    r_dv_neg  [QW];
    logic          r_dv_zero [QW];
    logic          r_dv_valid [QW];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            dv_in_len[k] = (k == 0) ? r_nm_len : r_dv_len[(k == 0) ? 0 : k - 1];
            dv_den[k]    = DW'(dv_in_len[k]) << (QW - 1 - k);
            for (int i = 0; i < 3; i++) begin
                dv_in_rem[k][i] = (k == 0) ? r_num[i] : r_dv_rem[(k == 0) ? 0 : k - 1][i];
                dv_in_q[k][i]   = (k == 0) ? '0 : r_dv_q[(k == 0) ? 0 : k - 1][i];
                n_dv_rem[k][i]  = dv_in_rem[k][i];
                n_dv_q[k][i]    = dv_in_q[k][i];
                if (dv_in_rem[k][i] >= dv_den[k]) begin
                    n_dv_rem[k][i]          = dv_in_rem[k][i] - dv_den[k];
                    n_dv_q[k][i][QW-1-k]    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) r_dv_valid[k] <= 1'b0;
        end else if (i_en) begin
            r_dv_valid[0] <= r_nm_valid;
            for (int k = 1; k < QW; k++) r_dv_valid[k] <= r_dv_valid[k-1];
        end
        if (i_en) begin
            r_dv_rem     <= n_dv_rem;
            r_dv_q       <= n_dv_q;
            r_dv_len     <= dv_in_len;
            r_dv_neg[0]  <= r_nm_neg;
            r_dv_zero[0] <= r_nm_zero;
            for (int k = 1; k < QW; k++) begin
                r_dv_neg[k]  <= r_dv_neg[k-1];
                r_dv_zero[k] <= r_dv_zero[k-1];
            end
        end
    end

    // sign, saturate, zero vector
    logic signed [EW-1:0] sv [3];
    logic signed [W-1:0]  n_unit [3];
    logic signed [W-1:0]  r_unit [3];
    logic                 r_zero, r_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sv[i] = $signed(EW'(r_dv_q[QW-1][i]));
            if (r_dv_neg[QW-1][i]) sv[i] = -sv[i];
            if (r_dv_zero[QW-1]) begin
                n_unit[i] = '0;
            end else if (sv[i] > SMX) begin
                n_unit[i] = SMX[W-1:0];
            end else if (sv[i] < SMN) begin
                n_unit[i] = SMN[W-1:0];
            end else begin
                n_unit[i] = sv[i][W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_dv_valid[QW-1];
        end
        if (i_en) begin
            r_unit <= n_unit;
            r_zero <= r_dv_zero[QW-1];
        end
    end

    assign o_valid = r_valid;
    assign o_unit  = r_unit;
    assign o_zero  = r_zero;

endmodule

// ----- src/vtm_cross.sv -----
// two-stage fixed point cross product with round half up and saturation
// depends on vtm_pkg for defaults
module vtm_cross #(
    parameter int W = vtm_pkg::COORD_WIDTH_DEF,
    parameter int F = vtm_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_a [3],
    input  logic signed [W-1:0] i_b [3],
    output logic                o_valid,
    output logic signed [W-1:0] o_c [3]
);
    localparam int XW = 2 * W + 2;
    localparam logic signed [XW-1:0] HALF = XW'(1) << (F - 1);
    localparam logic signed [XW-1:0] SMX  = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] SMN  = ~SMX;

    // stage 1: six products
    logic signed [2*W-1:0] r_p [6];
    logic                  r_p_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (i_en) begin
            r_p_valid <= i_valid;
        end
        if (i_en) begin
            r_p[0] <= i_a[1] * i_b[2];
            r_p[1] <= i_a[2] * i_b[1];
            r_p[2] <= i_a[2] * i_b[0];
            r_p[3] <= i_a[0] * i_b[2];
            r_p[4] <= i_a[0] * i_b[1];
            r_p[5] <= i_a[1] * i_b[0];
        end
    end

    // stage 2: difference, round, saturate
    logic signed [XW-1:0] diff [3];
    logic signed [XW-1:0] shf  [3];
    logic signed [W-1:0]  n_c  [3];
    logic signed [W-1:0]  r_c  [3];
    logic                 r_c_valid;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            diff[i] = XW'(r_p[2*i]) - XW'(r_p[2*i+1]) + HALF;
            shf[i]  = diff[i] >>> F;
            if (shf[i] > SMX) begin
                n_c[i] = SMX[W-1:0];
            end else if (shf[i] < SMN) begin
                n_c[i] = SMN[W-1:0];
            end else begin
                n_c[i] = shf[i][W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid <= r_p_valid;
        end
        if (i_en) begin
            r_c <= n_c;
        end
    end

    assign o_valid = r_c_valid;
    assign o_c     = r_c;

endmodule

// ----- src/vtm_xlate.sv -----
// three-stage translation term: minus dot product of a row with the eye point
// depends on vtm_pkg for defaults; carries the row alongside
module vtm_xlate #(
    parameter int W = vtm_pkg::COORD_WIDTH_DEF,
    parameter int F = vtm_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [W-1:0] i_row [3],
    input  logic signed [W-1:0] i_eye [3],
    output logic                o_valid,
    output logic signed [W-1:0] o_row [3],
    output logic signed [W-1:0] o_col3
);
    localparam int SW = 2 * W + 2;
    localparam int XW = SW + 1;
    localparam logic signed [XW-1:0] HALF = XW'(1) << (F - 1);
    localparam logic signed [XW-1:0] SMX  = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] SMN  = ~SMX;

    // stage 1: products
    logic signed [2*W-1:0] r1_p [3];
    logic signed [W-1:0]   r1_row [3];
    logic                  r1_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            for (int i = 0; i < 3; i++) r1_p[i] <= i_row[i] * i_eye[i];
            r1_row <= i_row;
        end
    end

    // stage 2: sum
    logic signed [SW-1:0] r2_sum;
    logic signed [W-1:0]  r2_row [3];
    logic                 r2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_sum <= SW'(r1_p[0]) + SW'(r1_p[1]) + SW'(r1_p[2]);
            r2_row <= r1_row;
        end
    end

    // stage 3: negate, round, saturate
    logic signed [XW-1:0] v, shf;
    logic signed [W-1:0]  n_col3, r3_col3;
    logic signed [W-1:0]  r3_row [3];
    logic                 r3_valid;

    always_comb begin
        v   = HALF - XW'(r2_sum);
        shf = v >>> F;
        if (shf > SMX) begin
            n_col3 = SMX[W-1:0];
        end else if (shf < SMN) begin
            n_col3 = SMN[W-1:0];
        end else begin
            n_col3 = shf[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            r3_col3 <= n_col3;
            r3_row  <= r2_row;
        end
    end

    assign o_valid = r3_valid;
    assign o_row   = r3_row;
    assign o_col3  = r3_col3;

endmodule

// ----- src/vtm_delay.sv -----
// stallable shift line that keeps side data aligned with the pipeline
// no dependencies
module vtm_delay #(
    parameter int DW    = 1,
    parameter int DEPTH = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_d,
    output logic [DW-1:0] o_q
);
    logic [DW-1:0] r_line [DEPTH];

    // shift on every advancing cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) r_line[k] <= r_line[k-1];
        end
    end

    assign o_q = r_line[DEPTH-1];

endmodule

// ----- src/view_transform_matrix_unit.sv -----
// Look-at view matrix unit. Each request carries eye, target and up in signed
// fixed point and yields four row results (left, true up, minus forward, 0 0 0 1)
// in order on the result channel. An accepted request passes through the input
// register, the normalizer (scaling, squares, 32-step square root, FRAC_BITS + 1
// step divider), two cross products, the translation dot product and the row
// serializer. The pipeline takes a request every cycle unless the row serializer
// stalls it; the single row output port sends the four rows of each matrix in turn.
// Depends on vtm_pkg, vtm_norm, vtm_cross, vtm_xlate, vtm_delay.
`include "view_transform_matrix_unit_macros.svh"
module view_transform_matrix_unit #(
    parameter int COORD_WIDTH = vtm_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = vtm_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_from_x,
    input  logic signed [COORD_WIDTH-1:0] i_from_y,
    input  logic signed [COORD_WIDTH-1:0] i_from_z,
    input  logic signed [COORD_WIDTH-1:0] i_to_x,
    input  logic signed [COORD_WIDTH-1:0] i_to_y,
    input  logic signed [COORD_WIDTH-1:0] i_to_z,
    input  logic signed [COORD_WIDTH-1:0] i_up_x,
    input  logic signed [COORD_WIDTH-1:0] i_up_y,
    input  logic signed [COORD_WIDTH-1:0] i_up_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_row_number,
    output logic signed [COORD_WIDTH-1:0] o_col0,
    output logic signed [COORD_WIDTH-1:0] o_col1,
    output logic signed [COORD_WIDTH-1:0] o_col2,
    output logic signed [COORD_WIDTH-1:0] o_col3,
    output logic                          o_degenerate,
    output logic                          o_last_row
);
    localparam int W  = COORD_WIDTH;
    localparam int MW = COORD_WIDTH + 1;
    localparam int NL = vtm_pkg::norm_lat(FRAC_BITS);
    localparam logic signed [W-1:0] SMAXW = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMINW = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] ONE_VAL =
        (FRAC_BITS >= COORD_WIDTH - 1) ? SMAXW : (W'(1) << FRAC_BITS);

    logic en;

    // input register: direction, up and eye
    logic signed [MW-1:0] r_d [3];
    logic signed [MW-1:0] r_up [3];
    logic signed [W-1:0]  r_eye [3];
    logic                 r_in_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (en) begin
            r_in_valid <= i_valid;
        end
        if (en) begin
            r_d[0]   <= MW'(i_to_x) - MW'(i_from_x);
            r_d[1]   <= MW'(i_to_y) - MW'(i_from_y);
            r_d[2]   <= MW'(i_to_z) - MW'(i_from_z);
            r_up[0]  <= MW'(i_up_x);
            r_up[1]  <= MW'(i_up_y);
            r_up[2]  <= MW'(i_up_z);
            r_eye[0] <= i_from_x;
            r_eye[1] <= i_from_y;
            r_eye[2] <= i_from_z;
        end
    end

    // normalize forward and up in parallel
    logic signed [W-1:0] f [3], un [3];
    logic                f_zero, u_zero, f_valid, u_valid;

    vtm_norm #(.W(W), .F(FRAC_BITS), .MW(MW)) u_norm_f (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_in_valid),
        .i_vec(r_d), .o_valid(f_valid), .o_unit(f), .o_zero(f_zero)
    );

    vtm_norm #(.W(W), .F(FRAC_BITS), .MW(MW)) u_norm_u (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_in_valid),
        .i_vec(r_up), .o_valid(u_valid), .o_unit(un), .o_zero(u_zero)
    );

    // left = forward x up
    logic signed [W-1:0] left [3];
    logic                left_valid;

    vtm_cross #(.W(W), .F(FRAC_BITS)) u_cross_left (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(f_valid),
        .i_a(f), .i_b(un), .o_valid(left_valid), .o_c(left)
    );

    // forward aligned with left, then with true up
    logic [3*W-1:0]      f_d2_flat, f_d4_flat;
    logic signed [W-1:0] f_d2 [3], f_d4 [3];

    vtm_delay #(.DW(3*W), .DEPTH(2)) u_dly_f2 (
        .i_clk(i_clk), .i_en(en), .i_d({f[2], f[1], f[0]}), .o_q(f_d2_flat)
    );
    vtm_delay #(.DW(3*W), .DEPTH(2)) u_dly_f4 (
        .i_clk(i_clk), .i_en(en), .i_d(f_d2_flat), .o_q(f_d4_flat)
    );

    // true up = left x forward
    logic signed [W-1:0] tu [3];
    logic                tu_valid;

    vtm_cross #(.W(W), .F(FRAC_BITS)) u_cross_tu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(left_valid),
        .i_a(left), .i_b(f_d2), .o_valid(tu_valid), .o_c(tu)
    );

    logic [3*W-1:0]      left_d2_flat;
    logic signed [W-1:0] left_d2 [3];

    vtm_delay #(.DW(3*W), .DEPTH(2)) u_dly_left (
        .i_clk(i_clk), .i_en(en), .i_d({left[2], left[1], left[0]}), .o_q(left_d2_flat)
    );

    // eye and degenerate flag kept in step
    logic [3*W-1:0]      eye_d_flat;
    logic signed [W-1:0] eye_d [3];
    logic                deg_d;

    vtm_delay #(.DW(3*W), .DEPTH(NL + 4)) u_dly_eye (
        .i_clk(i_clk), .i_en(en), .i_d({r_eye[2], r_eye[1], r_eye[0]}), .o_q(eye_d_flat)
    );
    vtm_delay #(.DW(1), .DEPTH(7)) u_dly_deg (
        .i_clk(i_clk), .i_en(en), .i_d(f_zero | u_zero), .o_q(deg_d)
    );

    // minus forward with saturation
    logic signed [W-1:0] nf [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            f_d2[i]    = f_d2_flat[i*W +: W];
            f_d4[i]    = f_d4_flat[i*W +: W];
            left_d2[i] = left_d2_flat[i*W +: W];
            eye_d[i]   = eye_d_flat[i*W +: W];
            nf[i]      = (f_d4[i] == SMINW) ? SMAXW : -f_d4[i];
        end
    end

    // translation column for the three rows
    logic signed [W-1:0] row0 [3], row1 [3], row2 [3];
    logic signed [W-1:0] t0, t1, t2;
    logic                xl_valid, xl1_valid, xl2_valid;

    vtm_xlate #(.W(W), .F(FRAC_BITS)) u_xl0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(tu_valid),
        .i_row(left_d2), .i_eye(eye_d), .o_valid(xl_valid), .o_row(row0), .o_col3(t0)
    );
    vtm_xlate #(.W(W), .F(FRAC_BITS)) u_xl1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(tu_valid),
        .i_row(tu), .i_eye(eye_d), .o_valid(xl1_valid), .o_row(row1), .o_col3(t1)
    );
    vtm_xlate #(.W(W), .F(FRAC_BITS)) u_xl2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(tu_valid),
        .i_row(nf), .i_eye(eye_d), .o_valid(xl2_valid), .o_row(row2), .o_col3(t2)
    );

    // row serializer: holds one matrix, sends a row per accepted result
    logic signed [W-1:0] r_m [3][4];
    logic [1:0]          r_cnt;
    logic                r_deg, r_ser_valid;
    logic                ser_free, ser_load;

    assign ser_free = !r_ser_valid || (i_ready && (r_cnt == vtm_pkg::ROW_LAST));
    assign ser_load = xl_valid && ser_free;
    assign en       = !xl_valid || ser_free;
    assign o_ready  = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_valid <= 1'b0;
            r_cnt       <= '0;
        end else if (ser_load) begin
            r_ser_valid <= 1'b1;
            r_cnt       <= '0;
        end else if (r_ser_valid && i_ready) begin
            if (r_cnt == vtm_pkg::ROW_LAST) begin
                r_ser_valid <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            for (int c = 0; c < 3; c++) begin
                r_m[0][c] <= row0[c];
                r_m[1][c] <= row1[c];
                r_m[2][c] <= row2[c];
            end
            r_m[0][3] <= t0;
            r_m[1][3] <= t1;
            r_m[2][3] <= t2;
            r_deg     <= deg_d;
        end
    end

    // output row select
    always_comb begin
        o_valid      = r_ser_valid;
        o_row_number = r_cnt;
        o_degenerate = r_deg;
        o_last_row   = (r_cnt == vtm_pkg::ROW_LAST);
        unique case (r_cnt)
            2'd0: begin
                o_col0 = r_m[0][0]; o_col1 = r_m[0][1]; o_col2 = r_m[0][2]; o_col3 = r_m[0][3];
            end
            2'd1: begin
                o_col0 = r_m[1][0]; o_col1 = r_m[1][1]; o_col2 = r_m[1][2]; o_col3 = r_m[1][3];
            end
            2'd2: begin
                o_col0 = r_m[2][0]; o_col1 = r_m[2][1]; o_col2 = r_m[2][2]; o_col3 = r_m[2][3];
            end
            default: begin
                o_col0 = '0; o_col1 = '0; o_col2 = '0; o_col3 = ONE_VAL;
            end
        endcase
    end

    // checks on row sequencing, stall behavior and lane valid alignment
    `VTM_ASSERT_NEXT(a_row_step, o_valid && i_ready && !o_last_row, o_valid && (o_row_number == $past(o_row_number) + 2'd1))
    `VTM_ASSERT_NEXT(a_deg_hold, o_valid && i_ready && !o_last_row, o_degenerate == $past(o_degenerate))
    `VTM_ASSERT_NOW(a_stall, xl_valid && r_ser_valid && !(i_ready && o_last_row), !o_ready)
    `VTM_ASSERT_NOW(a_lanes, xl_valid || xl1_valid || xl2_valid || f_valid || u_valid, (xl_valid == xl1_valid) && (xl_valid == xl2_valid) && (f_valid == u_valid))

endmodule

// ----- verif/view_transform_matrix_unit_tb.sv -----
// testbench for the look-at view matrix unit: random and directed eye/target/up
// requests, with the four expected matrix rows computed in the bench and compared
// depends on view_transform_matrix_unit and vtm_pkg
module view_transform_matrix_unit_tb;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam int LIMIT = 400000;

    typedef struct {
        logic signed [CW-1:0] fx, fy, fz, tx, ty, tz, ux, uy, uz;
    } view_req_t;

    typedef struct {
        logic [1:0]           row;
        logic signed [CW-1:0] c0, c1, c2, c3;
        logic                 degen;
        logic                 last;
    } matrix_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic signed [CW-1:0] i_from_x, i_from_y, i_from_z;
    logic signed [CW-1:0] i_to_x, i_to_y, i_to_z;
    logic signed [CW-1:0] i_up_x, i_up_y, i_up_z;
    logic                 o_valid;
    logic                 i_ready;
    logic [1:0]           o_row_number;
    logic signed [CW-1:0] o_col0, o_col1, o_col2, o_col3;
    logic                 o_degenerate;
    logic                 o_last_row;

    view_transform_matrix_unit dut (.*);

    view_req_t   pending_reqs[$];
    matrix_row_t expected_rows[$];
    int          mismatches;
    int          cycle_count = 0;
    int          send_wait;
    int          recv_wait;
    bit          stim_done;
    bit          drain_hold;
    bit          req_taken;

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint clamp(input longint v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    // arithmetic shift right by the fraction bits with round half up
    function automatic logic signed [127:0] round_frac(input logic signed [127:0] x);
        return (x + (128'sd1 <<< (FB - 1))) >>> FB;
    endfunction

    function automatic longint clamp_wide(input logic signed [127:0] x);
        if (x > 128'sd2147483647) return SMAX;
        if (x < -128'sd2147483648) return SMIN;
        return longint'(x);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // unit vector in fixed point; returns 1 for a zero vector
    function automatic bit unit_vec(input longint v[3], output longint o[3]);
        longint unsigned m[3];
        longint unsigned mx, sum, len, q;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i] < 0 ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            for (int i = 0; i < 3; i++) o[i] = 0;
            return 1'b1;
        end
        while (mx >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] >>= 1;
            mx >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) m[i] <<= 1;
            mx <<= 1;
        end
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FB) + len / 2) / len;
            o[i] = clamp(v[i] < 0 ? -longint'(q) : longint'(q));
        end
        return 1'b0;
    endfunction

    function automatic void cross_fixed(input longint a[3], input longint b[3],
                                        output longint o[3]);
        for (int i = 0; i < 3; i++) begin
            int j, k;
            logic signed [127:0] p;
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            p = 128'(a[j]) * 128'(b[k]) - 128'(a[k]) * 128'(b[j]);
            o[i] = clamp_wide(round_frac(p));
        end
    endfunction

    // four expected rows of the look-at matrix for one request
    function automatic void predict_view_rows(input view_req_t rq);
        longint eye[3], dir[3], up[3], fwd[3], upn[3], lft[3], tup[3], nfw[3];
        longint rw[3];
        logic signed [127:0] acc;
        bit degen;
        matrix_row_t r;
        eye = '{longint'(rq.fx), longint'(rq.fy), longint'(rq.fz)};
        dir = '{longint'(rq.tx) - eye[0], longint'(rq.ty) - eye[1],
                longint'(rq.tz) - eye[2]};
        up  = '{longint'(rq.ux), longint'(rq.uy), longint'(rq.uz)};
        degen = unit_vec(dir, fwd);
        degen = unit_vec(up, upn) | degen;
        cross_fixed(fwd, upn, lft);
        cross_fixed(lft, fwd, tup);
        for (int i = 0; i < 3; i++) nfw[i] = clamp(-fwd[i]);
        for (int k = 0; k < 4; k++) begin
            case (k)
                0: rw = lft;
                1: rw = tup;
                2: rw = nfw;
                default: rw = '{0, 0, 0};
            endcase
            r.row = 2'(k);
            r.c0 = rw[0][CW-1:0];
            r.c1 = rw[1][CW-1:0];
            r.c2 = rw[2][CW-1:0];
            if (k < 3) begin
                acc = 0;
                for (int i = 0; i < 3; i++) acc += 128'(rw[i]) * 128'(eye[i]);
                r.c3 = 32'(clamp_wide(round_frac(-acc)));
            end else begin
                r.c3 = 32'(clamp(64'sd1 <<< FB));
            end
            r.degen = degen;
            r.last = (k == 3);
            expected_rows.push_back(r);
        end
    endfunction

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return 32'($signed($urandom_range(0, 65536 * 200)) - 65536 * 100);
            default: return $urandom;
        endcase
    endfunction

    function automatic view_req_t rand_req();
        view_req_t rq;
        rq.fx = rand_coord(); rq.fy = rand_coord(); rq.fz = rand_coord();
        rq.tx = rand_coord(); rq.ty = rand_coord(); rq.tz = rand_coord();
        rq.ux = rand_coord(); rq.uy = rand_coord(); rq.uz = rand_coord();
        case ($urandom_range(0, 9))
            0: begin rq.tx = rq.fx; rq.ty = rq.fy; rq.tz = rq.fz; end
            1: begin rq.ux = 0; rq.uy = 0; rq.uz = 0; end
            2: begin rq.ux = 0; rq.uy = 32'sh10000; rq.uz = 0; end
            default: ;
        endcase
        return rq;
    endfunction

    // request list: directed corners, then random
    initial begin
        view_req_t rq;
        logic signed [CW-1:0] ext[4];
        ext = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh10000};
        rq = '{0, 0, 0, 0, 0, -32'sh10000, 0, 32'sh10000, 0};
        pending_reqs.push_back(rq);
        rq = '{32'sh30000, 32'sh20000, 32'sh50000, 0, 0, 0, 0, 32'sh10000, 0};
        pending_reqs.push_back(rq);
        rq = '{5, 5, 5, 5, 5, 5, 0, 32'sh10000, 0};          // target equals eye
        pending_reqs.push_back(rq);
        rq = '{0, 0, 0, 32'sh10000, 0, 0, 0, 0, 0};          // zero up
        pending_reqs.push_back(rq);
        rq = '{0, 0, 0, 32'sh10000, 0, 0, 32'sh10000, 0, 0}; // up parallel to forward
        pending_reqs.push_back(rq);
        rq = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
               32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000};
        pending_reqs.push_back(rq);
        rq = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
               32'sh7fffffff, 1, -1, 1};
        pending_reqs.push_back(rq);
        rq = '{0, 0, 0, 1, 0, 0, 0, 0, 1};                   // tiny vectors scale up
        pending_reqs.push_back(rq);
        for (int i = 0; i < 12; i++) begin
            rq.fx = ext[i % 4]; rq.fy = ext[(i + 1) % 4]; rq.fz = ext[(i + 2) % 4];
            rq.tx = ext[(i + 3) % 4]; rq.ty = ext[i % 4]; rq.tz = ext[(i / 4) % 4];
            rq.ux = ext[(i + 1) % 4]; rq.uy = ext[(i + 3) % 4]; rq.uz = ext[(i / 3) % 4];
            pending_reqs.push_back(rq);
        end
        for (int i = 0; i < 330; i++) pending_reqs.push_back(rand_req());
    end

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_wait <= $urandom_range(0, 12);
        end else if (i_valid && !req_taken) begin
            // hold the request until taken
        end else if (pending_reqs.size() == 0) begin
            i_valid <= 1'b0;
            stim_done <= 1'b1;
        end else if (pending_reqs.size() == 200 && expected_rows.size() != 0 && !drain_hold) begin
            // let the pipeline drain once
            i_valid <= 1'b0;
        end else if (send_wait != 0 && !(pending_reqs.size() > 300 && pending_reqs.size() < 330)) begin
            i_valid <= 1'b0;
            send_wait <= send_wait - 1;
        end else begin
            if (pending_reqs.size() == 200) drain_hold <= 1'b1;
            i_valid  <= 1'b1;
            i_from_x <= pending_reqs[0].fx;
            i_from_y <= pending_reqs[0].fy;
            i_from_z <= pending_reqs[0].fz;
            i_to_x   <= pending_reqs[0].tx;
            i_to_y   <= pending_reqs[0].ty;
            i_to_z   <= pending_reqs[0].tz;
            i_up_x   <= pending_reqs[0].ux;
            i_up_y   <= pending_reqs[0].uy;
            i_up_z   <= pending_reqs[0].uz;
            send_wait <= $urandom_range(0, 12);
        end
    end

    // result-side backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            recv_wait <= 0;
        end else if (i_ready && o_valid) begin
            recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            i_ready <= 1'b0;
        end else if (recv_wait != 0) begin
            recv_wait <= recv_wait - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // accept requests and check rows
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            req_taken <= i_valid && o_ready;
            if (i_valid && o_ready) begin
                predict_view_rows(pending_reqs.pop_front());
            end
            if (o_valid && i_ready) begin
                if (expected_rows.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected row %0d", o_row_number);
                end else begin
                    matrix_row_t e;
                    e = expected_rows.pop_front();
                    if (o_row_number !== e.row || o_col0 !== e.c0 || o_col1 !== e.c1 ||
                        o_col2 !== e.c2 || o_col3 !== e.c3 ||
                        o_degenerate !== e.degen || o_last_row !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("row mismatch exp %0d %h %h %h %h %b %b got %0d %h %h %h %h %b %b",
                                     e.row, e.c0, e.c1, e.c2, e.c3, e.degen, e.last,
                                     o_row_number, o_col0, o_col1, o_col2, o_col3,
                                     o_degenerate, o_last_row);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // reset and end of run
    initial begin
        mismatches = 0;
        stim_done = 1'b0;
        drain_hold = 1'b0;
        req_taken = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        {i_from_x, i_from_y, i_from_z, i_to_x, i_to_y, i_to_z, i_up_x, i_up_y, i_up_z} = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (stim_done && expected_rows.size() == 0);
        repeat (FB + 100) @(posedge i_clk);
        if (mismatches == 0 && expected_rows.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/vtm_pkg.sv
src/vtm_norm.sv
src/vtm_cross.sv
src/vtm_xlate.sv
src/vtm_delay.sv
src/view_transform_matrix_unit.sv
verif/view_transform_matrix_unit_tb.sv
